/* rtl/weighted_curve_subdivider_top_assert.svh */
// assertion macros used by the curve subdivider controller
// depends on nothing; included by files that check their own logic
`ifndef WEIGHTED_CURVE_SUBDIVIDER_TOP_ASSERT_SVH
`define WEIGHTED_CURVE_SUBDIVIDER_TOP_ASSERT_SVH
`ifndef SYNTH
`define WCS_ASSERT_IMP(lbl, ck, rs, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!rs) (ante) |-> (cons)) \
    else $error("assertion failed");
`define WCS_ASSERT_NXT(lbl, ck, rs, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!rs) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define WCS_ASSERT_IMP(lbl, ck, rs, ante, cons)
`define WCS_ASSERT_NXT(lbl, ck, rs, ante, cons)
`endif
`endif

/* rtl/wcs_pkg.sv */
// types, codes and constants of the weighted curve subdivider
// no dependencies
package wcs_pkg;

  localparam int AddrW  = 10;
  localparam int CountW = 11;
  localparam logic [CountW-1:0] MaxPoints = 11'd1024;
  localparam logic [9:0] MidCoef = 10'd1000;

  typedef struct packed {
    logic              operation;
    logic signed [31:0] coord_x;
    logic signed [31:0] coord_y;
    logic signed [31:0] coord_z;
    logic              break_point;
    logic              last_point;
    logic [9:0]        read_index;
  } in_req_t;

  typedef struct packed {
    logic signed [31:0] out_x;
    logic signed [31:0] out_y;
    logic signed [31:0] out_z;
    logic              out_break;
    logic [10:0]       point_count;
    logic [9:0]        rotation_count;
    logic [1:0]        status;
  } out_res_t;

  typedef struct packed {
    logic [31:0] x;
    logic [31:0] y;
    logic [31:0] z;
    logic        brk;
    logic        fix;
  } pt_t;

  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_READ = 1'b1;

  localparam logic [1:0] STAT_OK    = 2'd0;
  localparam logic [1:0] STAT_FEW   = 2'd1;
  localparam logic [1:0] STAT_CAP   = 2'd2;
  localparam logic [1:0] STAT_INDEX = 2'd3;

  localparam logic [1:0] CFG_CLOSED = 2'd0;
  localparam logic [1:0] CFG_PASSES = 2'd1;
  localparam logic [1:0] CFG_WEIGHT = 2'd2;

  // write data select
  localparam logic [1:0] WS_LOAD = 2'd0;
  localparam logic [1:0] WS_COPY = 2'd1;
  localparam logic [1:0] WS_NEW  = 2'd2;
  localparam logic [1:0] WS_MID  = 2'd3;

  // window register update
  localparam logic [2:0] CAP_NONE   = 3'd0;
  localparam logic [2:0] CAP_WL     = 3'd1;
  localparam logic [2:0] CAP_WR     = 3'd2;
  localparam logic [2:0] CAP_CUR    = 3'd3;
  localparam logic [2:0] CAP_NXT_RD = 3'd4;
  localparam logic [2:0] CAP_NXT_WR = 3'd5;
  localparam logic [2:0] CAP_SHIFT  = 3'd6;

  typedef struct packed {
    logic [AddrW-1:0] rd_addr;
    logic             rd_sel_b;
    logic             we_a;
    logic             we_b;
    logic [AddrW-1:0] wr_addr;
    logic [1:0]       wr_sel;
    logic             force_brk;
    logic [2:0]       cap;
    logic             ar_start;
    logic             smooth;
  } cmd_t;

  typedef struct packed {
    logic rd_brk;
    logic ar_done;
  } sts_t;

endpackage

/* rtl/wcs_lane.sv */
// one coordinate lane: weighted sum then a bit-serial rounded division
// depends on wcs_pkg
module wcs_lane (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic        smooth,
  input  logic [15:0] weight,
  input  logic [31:0] l,
  input  logic [31:0] r,
  input  logic [31:0] p,
  output logic [31:0] q,
  output logic        busy
);

  logic [32:0] olr;
  logic [16:0] cc, dv;
  logic [48:0] u;
  logic [16:0] rem_r, rem_nxt;
  logic [31:0] quo_r, quo_nxt;
  logic [16:0] d_r;
  logic [5:0]  cnt_r;
  logic        busy_r;
  logic [17:0] trial, diff;
  logic        ge;

  // offset binary so the sum is unsigned
  assign olr = {1'b0, ~l[31], l[30:0]} + {1'b0, ~r[31], r[30:0]};
  assign cc  = smooth ? ({1'b0, weight} + 17'd2000) : {1'b0, weight};
  assign dv  = smooth ? ({1'b0, weight} + 17'd4000) : ({1'b0, weight} + 17'd2000);
  assign u   = 49'(olr) * 49'(wcs_pkg::MidCoef)
             + 49'(cc) * 49'({~p[31], p[30:0]}) + 49'(dv >> 1);

  assign trial   = {rem_r, quo_r[31]};
  assign diff    = trial - {1'b0, d_r};
  assign ge      = trial >= {1'b0, d_r};
  assign rem_nxt = ge ? diff[16:0] : trial[16:0];
  assign quo_nxt = {quo_r[30:0], ge};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= 6'd0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= 6'd32;
    end else if (busy_r) begin
      cnt_r <= cnt_r - 6'd1;
      if (cnt_r == 6'd1) begin
        busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= u[48:32];
      quo_r <= u[31:0];
      d_r   <= dv;
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      quo_r <= quo_nxt;
    end
  end

  assign q    = {~quo_r[31], quo_r[30:0]};
  assign busy = busy_r;

endmodule

/* rtl/wcs_dp.sv */
// datapath: point and scratch memories, neighbor window, three coordinate lanes
// depends on wcs_pkg and wcs_lane
module wcs_dp (
  input  logic             clk,
  input  logic             rst_n,
  input  wcs_pkg::cmd_t    cmd,
  input  wcs_pkg::in_req_t in_req,
  input  logic [15:0]      weight,
  output wcs_pkg::sts_t    sts,
  output wcs_pkg::pt_t     rd_pt
);

  wcs_pkg::pt_t mem_a [1024];
  wcs_pkg::pt_t mem_b [1024];
  wcs_pkg::pt_t qa_r, qb_r;
  logic         selb_r;
  wcs_pkg::pt_t prev_r, cur_r, nxt_r, wl_r, wr_r;
  wcs_pkg::pt_t wdata;
  logic [31:0]  ml_x, ml_y, ml_z, mr_x, mr_y, mr_z;
  logic [31:0]  q_x, q_y, q_z;
  logic         bx, by, bz, keep;

  function automatic logic [31:0] mid2(input logic [31:0] a, input logic [31:0] b);
    logic [32:0] s;
    begin
      s = {1'b0, ~a[31], a[30:0]} + {1'b0, ~b[31], b[30:0]} + 33'd1;
      mid2 = {~s[32], s[31:1]};
    end
  endfunction

  always_ff @(posedge clk) begin
    if (cmd.we_a) begin
      mem_a[cmd.wr_addr] <= wdata;
    end
    qa_r <= mem_a[cmd.rd_addr];
  end

  always_ff @(posedge clk) begin
    if (cmd.we_b) begin
      mem_b[cmd.wr_addr] <= wdata;
    end
    qb_r <= mem_b[cmd.rd_addr];
  end

  always_ff @(posedge clk) begin
    selb_r <= cmd.rd_sel_b;
  end

  assign rd_pt = selb_r ? qb_r : qa_r;

  always_ff @(posedge clk) begin
    unique case (cmd.cap)
      wcs_pkg::CAP_WL:     wl_r <= rd_pt;
      wcs_pkg::CAP_WR:     wr_r <= rd_pt;
      wcs_pkg::CAP_CUR: begin
        cur_r  <= rd_pt;
        prev_r <= wl_r;
      end
      wcs_pkg::CAP_NXT_RD: nxt_r <= rd_pt;
      wcs_pkg::CAP_NXT_WR: nxt_r <= wr_r;
      wcs_pkg::CAP_SHIFT: begin
        prev_r <= cur_r;
        cur_r  <= nxt_r;
      end
      default: ;
    endcase
  end

  assign ml_x = mid2(prev_r.x, cur_r.x);
  assign ml_y = mid2(prev_r.y, cur_r.y);
  assign ml_z = mid2(prev_r.z, cur_r.z);
  assign mr_x = mid2(cur_r.x, nxt_r.x);
  assign mr_y = mid2(cur_r.y, nxt_r.y);
  assign mr_z = mid2(cur_r.z, nxt_r.z);

  // refinement uses neighbor midpoints, the smoothing pass the neighbors
  wcs_lane u_lane_x (
    .clk(clk), .rst_n(rst_n), .start(cmd.ar_start), .smooth(cmd.smooth),
    .weight(weight), .l(cmd.smooth ? prev_r.x : ml_x),
    .r(cmd.smooth ? nxt_r.x : mr_x), .p(cur_r.x), .q(q_x), .busy(bx)
  );
  wcs_lane u_lane_y (
    .clk(clk), .rst_n(rst_n), .start(cmd.ar_start), .smooth(cmd.smooth),
    .weight(weight), .l(cmd.smooth ? prev_r.y : ml_y),
    .r(cmd.smooth ? nxt_r.y : mr_y), .p(cur_r.y), .q(q_y), .busy(by)
  );
  wcs_lane u_lane_z (
    .clk(clk), .rst_n(rst_n), .start(cmd.ar_start), .smooth(cmd.smooth),
    .weight(weight), .l(cmd.smooth ? prev_r.z : ml_z),
    .r(cmd.smooth ? nxt_r.z : mr_z), .p(cur_r.z), .q(q_z), .busy(bz)
  );

  assign keep = cmd.smooth ? cur_r.brk : cur_r.fix;

  always_comb begin
    wdata = cur_r;
    unique case (cmd.wr_sel)
      wcs_pkg::WS_LOAD: begin
        wdata.x   = in_req.coord_x;
        wdata.y   = in_req.coord_y;
        wdata.z   = in_req.coord_z;
        wdata.brk = in_req.break_point;
        wdata.fix = 1'b0;
      end
      wcs_pkg::WS_COPY: begin
        wdata     = rd_pt;
        wdata.brk = rd_pt.brk | cmd.force_brk;
        wdata.fix = rd_pt.brk | cmd.force_brk;
      end
      wcs_pkg::WS_NEW: begin
        if (!keep) begin
          wdata.x = q_x;
          wdata.y = q_y;
          wdata.z = q_z;
        end
      end
      wcs_pkg::WS_MID: begin
        wdata.x   = mr_x;
        wdata.y   = mr_y;
        wdata.z   = mr_z;
        wdata.brk = 1'b0;
        wdata.fix = cur_r.fix & nxt_r.fix;
      end
      default: ;
    endcase
  end

  assign sts.rd_brk  = rd_pt.brk;
  assign sts.ar_done = !(bx | by | bz);

endmodule

/* rtl/wcs_ctrl.sv */
// controller: request handling, rotation scan, copy and refinement sequencing
// depends on wcs_pkg and the assertion macro header
`include "weighted_curve_subdivider_top_assert.svh"
module wcs_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  output logic             busy,
  input  wcs_pkg::in_req_t in_req,
  input  logic             closed,
  input  logic [3:0]       passes,
  input  wcs_pkg::sts_t    sts,
  output wcs_pkg::cmd_t    cmd,
  output logic             out_valid,
  output logic             show,
  output logic [1:0]       status,
  output logic [10:0]      point_count,
  output logic [9:0]       rotation_count
);

  localparam logic [4:0] ST_IDLE    = 5'd0;
  localparam logic [4:0] ST_RESP    = 5'd1;
  localparam logic [4:0] ST_CHECK   = 5'd2;
  localparam logic [4:0] ST_SCAN_RD = 5'd3;
  localparam logic [4:0] ST_SCAN_CK = 5'd4;
  localparam logic [4:0] ST_PREP_RD = 5'd5;
  localparam logic [4:0] ST_PREP_WR = 5'd6;
  localparam logic [4:0] ST_PRE1    = 5'd7;
  localparam logic [4:0] ST_PRE2    = 5'd8;
  localparam logic [4:0] ST_PRE3    = 5'd9;
  localparam logic [4:0] ST_CUR     = 5'd10;
  localparam logic [4:0] ST_RD      = 5'd11;
  localparam logic [4:0] ST_NXT     = 5'd12;
  localparam logic [4:0] ST_GO      = 5'd13;
  localparam logic [4:0] ST_WAIT    = 5'd14;
  localparam logic [4:0] ST_W0      = 5'd15;
  localparam logic [4:0] ST_W1      = 5'd16;
  localparam logic [4:0] ST_ADV     = 5'd17;

  logic [4:0]  state_r, state_nxt;
  logic [10:0] loaded_r, loaded_nxt, result_r, result_nxt;
  logic [9:0]  rot_r, rot_nxt, k_r, k_nxt, src_r, src_nxt;
  logic [1:0]  status_r, status_nxt;
  logic        show_r, show_nxt;
  logic [10:0] n_r, n_nxt, i_r, i_nxt, c_r, c_nxt, cnt_r, cnt_nxt;
  logic [3:0]  pc_r, pc_nxt;
  logic        srcb_r, srcb_nxt, smooth_r, smooth_nxt;
  logic [10:0] segs, m_w, i_inc;
  logic [26:0] total_w;

  assign segs    = closed ? loaded_r : loaded_r - 11'd1;
  assign total_w = ({16'd0, segs} << passes) + 27'd1;
  assign m_w     = closed ? n_r + 11'd1 : n_r;
  assign i_inc   = i_r + 11'd1;

  always_comb begin
    state_nxt  = state_r;
    loaded_nxt = loaded_r;
    result_nxt = result_r;
    rot_nxt    = rot_r;
    k_nxt      = k_r;
    src_nxt    = src_r;
    status_nxt = status_r;
    show_nxt   = show_r;
    n_nxt      = n_r;
    i_nxt      = i_r;
    c_nxt      = c_r;
    cnt_nxt    = cnt_r;
    pc_nxt     = pc_r;
    srcb_nxt   = srcb_r;
    smooth_nxt = smooth_r;
    cmd           = '0;
    cmd.rd_sel_b  = srcb_r;
    cmd.smooth    = smooth_r;
    unique case (state_r)
      ST_IDLE: begin
        cmd.rd_sel_b = 1'b0;
        cmd.rd_addr  = in_req.read_index;
        if (start) begin
          if (in_req.operation == wcs_pkg::OP_LOAD) begin
            show_nxt = 1'b0;
            if (loaded_r < wcs_pkg::MaxPoints) begin
              cmd.we_a    = 1'b1;
              cmd.wr_addr = loaded_r[9:0];
              cmd.wr_sel  = wcs_pkg::WS_LOAD;
              loaded_nxt  = loaded_r + 11'd1;
              status_nxt  = wcs_pkg::STAT_OK;
            end else begin
              status_nxt = wcs_pkg::STAT_CAP;
            end
            state_nxt = in_req.last_point ? ST_CHECK : ST_RESP;
          end else begin
            if ({1'b0, in_req.read_index} < result_r) begin
              status_nxt = wcs_pkg::STAT_OK;
              show_nxt   = 1'b1;
            end else begin
              status_nxt = wcs_pkg::STAT_INDEX;
              show_nxt   = 1'b0;
            end
            state_nxt = ST_RESP;
          end
        end
      end
      ST_RESP: state_nxt = ST_IDLE;
      ST_CHECK: begin
        loaded_nxt = 11'd0;
        n_nxt      = loaded_r;
        i_nxt      = 11'd0;
        src_nxt    = 10'd0;
        k_nxt      = 10'd0;
        if (loaded_r < 11'd2) begin
          status_nxt = wcs_pkg::STAT_FEW;
          result_nxt = loaded_r;
          rot_nxt    = 10'd0;
          state_nxt  = ST_RESP;
        end else if (total_w > 27'(wcs_pkg::MaxPoints)) begin
          status_nxt = wcs_pkg::STAT_CAP;
          result_nxt = loaded_r;
          rot_nxt    = 10'd0;
          state_nxt  = ST_RESP;
        end else begin
          cnt_nxt   = total_w[10:0];
          state_nxt = closed ? ST_SCAN_RD : ST_PREP_RD;
        end
      end
      ST_SCAN_RD: begin
        cmd.rd_sel_b = 1'b0;
        cmd.rd_addr  = i_r[9:0];
        state_nxt    = ST_SCAN_CK;
      end
      ST_SCAN_CK: begin
        if (sts.rd_brk) begin
          k_nxt     = i_r[9:0];
          src_nxt   = i_r[9:0];
          i_nxt     = 11'd0;
          state_nxt = ST_PREP_RD;
        end else if (i_inc == n_r) begin
          // no break anywhere: refine as one loop
          i_nxt     = 11'd0;
          state_nxt = ST_PREP_RD;
        end else begin
          i_nxt     = i_inc;
          state_nxt = ST_SCAN_RD;
        end
      end
      ST_PREP_RD: begin
        cmd.rd_sel_b = 1'b0;
        cmd.rd_addr  = src_r;
        state_nxt    = ST_PREP_WR;
      end
      ST_PREP_WR: begin
        cmd.we_b      = 1'b1;
        cmd.wr_addr   = i_r[9:0];
        cmd.wr_sel    = wcs_pkg::WS_COPY;
        cmd.force_brk = !closed && (i_r == 11'd0 || i_inc == n_r);
        src_nxt       = ({1'b0, src_r} + 11'd1 == n_r) ? 10'd0 : src_r + 10'd1;
        i_nxt         = i_inc;
        if (i_inc == m_w) begin
          c_nxt      = m_w;
          pc_nxt     = 4'd0;
          srcb_nxt   = 1'b1;
          smooth_nxt = (passes == 4'd0);
          state_nxt  = ST_PRE1;
        end else begin
          state_nxt = ST_PREP_RD;
        end
      end
      ST_PRE1: begin
        cmd.rd_addr = 10'(c_r - 11'd2);
        state_nxt   = ST_PRE2;
      end
      ST_PRE2: begin
        cmd.cap     = wcs_pkg::CAP_WL;
        cmd.rd_addr = 10'd1;
        state_nxt   = ST_PRE3;
      end
      ST_PRE3: begin
        cmd.cap     = wcs_pkg::CAP_WR;
        cmd.rd_addr = 10'd0;
        state_nxt   = ST_CUR;
      end
      ST_CUR: begin
        cmd.cap   = wcs_pkg::CAP_CUR;
        i_nxt     = 11'd0;
        state_nxt = ST_RD;
      end
      ST_RD: begin
        cmd.rd_addr = i_inc[9:0];
        state_nxt   = ST_NXT;
      end
      ST_NXT: begin
        // past the end the right neighbor wraps to the second point
        cmd.cap   = (i_inc < c_r) ? wcs_pkg::CAP_NXT_RD : wcs_pkg::CAP_NXT_WR;
        state_nxt = ST_GO;
      end
      ST_GO: begin
        cmd.ar_start = 1'b1;
        state_nxt    = ST_WAIT;
      end
      ST_WAIT: begin
        if (sts.ar_done) begin
          state_nxt = ST_W0;
        end
      end
      ST_W0: begin
        cmd.wr_sel = wcs_pkg::WS_NEW;
        if (smooth_r) begin
          cmd.we_a    = 1'b1;
          cmd.wr_addr = i_r[9:0];
          state_nxt   = ST_ADV;
        end else begin
          cmd.we_a    = srcb_r;
          cmd.we_b    = !srcb_r;
          cmd.wr_addr = {i_r[8:0], 1'b0};
          state_nxt   = (i_inc < c_r) ? ST_W1 : ST_ADV;
        end
      end
      ST_W1: begin
        cmd.wr_sel  = wcs_pkg::WS_MID;
        cmd.we_a    = srcb_r;
        cmd.we_b    = !srcb_r;
        cmd.wr_addr = {i_r[8:0], 1'b1};
        state_nxt   = ST_ADV;
      end
      ST_ADV: begin
        cmd.cap = wcs_pkg::CAP_SHIFT;
        if (i_inc == c_r) begin
          if (smooth_r) begin
            result_nxt = cnt_r;
            rot_nxt    = k_r;
            status_nxt = wcs_pkg::STAT_OK;
            show_nxt   = 1'b0;
            state_nxt  = ST_RESP;
          end else begin
            c_nxt      = {c_r[9:0], 1'b0} - 11'd1;
            pc_nxt     = pc_r + 4'd1;
            srcb_nxt   = !srcb_r;
            smooth_nxt = (pc_r + 4'd1 == passes);
            state_nxt  = ST_PRE1;
          end
        end else begin
          i_nxt     = i_inc;
          state_nxt = ST_RD;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      loaded_r <= 11'd0;
      result_r <= 11'd0;
      rot_r    <= 10'd0;
      k_r      <= 10'd0;
      src_r    <= 10'd0;
      status_r <= wcs_pkg::STAT_OK;
      show_r   <= 1'b0;
      n_r      <= 11'd0;
      i_r      <= 11'd0;
      c_r      <= 11'd0;
      cnt_r    <= 11'd0;
      pc_r     <= 4'd0;
      srcb_r   <= 1'b0;
      smooth_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      loaded_r <= loaded_nxt;
      result_r <= result_nxt;
      rot_r    <= rot_nxt;
      k_r      <= k_nxt;
      src_r    <= src_nxt;
      status_r <= status_nxt;
      show_r   <= show_nxt;
      n_r      <= n_nxt;
      i_r      <= i_nxt;
      c_r      <= c_nxt;
      cnt_r    <= cnt_nxt;
      pc_r     <= pc_nxt;
      srcb_r   <= srcb_nxt;
      smooth_r <= smooth_nxt;
    end
  end

  assign busy           = state_r != ST_IDLE;
  assign out_valid      = state_r == ST_RESP;
  assign show           = show_r;
  assign status         = status_r;
  assign point_count    = result_r;
  assign rotation_count = rot_r;

  `WCS_ASSERT_NXT(a_resp_single, clk, rst_n, state_r == ST_RESP, state_r == ST_IDLE)
  `WCS_ASSERT_IMP(a_one_store_write, clk, rst_n, 1'b1, !(cmd.we_a && cmd.we_b))
  `WCS_ASSERT_NXT(a_lane_busy, clk, rst_n, cmd.ar_start, !sts.ar_done)
  `WCS_ASSERT_IMP(a_mid_in_range, clk, rst_n, state_r == ST_W1, i_inc < c_r)

endmodule

/* rtl/weighted_curve_subdivider_top.sv */
// Load or read: accepted at start; the result is strobed on the next cycle, except
// after a last-point load, which runs the curve computation; each point of each pass
// waits on the 32-step serial divider in each coordinate lane.
// The computation copies the points into the scratch store, then refines pass by pass.
// Synchronous active-low reset clears control and sets configuration to defaults; stores are not cleared.
// The receiver takes every strobed result; start is ignored while busy is high.
module weighted_curve_subdivider_top (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  wcs_pkg::in_req_t  in_req,
  output logic              out_valid,
  output wcs_pkg::out_res_t out_res,
  input  logic              cfg_we,
  input  logic [1:0]        cfg_index,
  input  logic [15:0]       cfg_data
);

  logic          closed_r;
  logic [3:0]    passes_r;
  logic [15:0]   weight_r;
  wcs_pkg::cmd_t cmd;
  wcs_pkg::sts_t sts;
  wcs_pkg::pt_t  rd_pt;
  logic          show;
  logic [1:0]    status;
  logic [10:0]   point_count;
  logic [9:0]    rotation_count;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      closed_r <= 1'b0;
      passes_r <= 4'd3;
      weight_r <= 16'd2000;
    end else if (cfg_we) begin
      unique case (cfg_index)
        wcs_pkg::CFG_CLOSED: closed_r <= cfg_data[0];
        wcs_pkg::CFG_PASSES: passes_r <= cfg_data[3:0];
        wcs_pkg::CFG_WEIGHT: weight_r <= cfg_data;
        default: ;
      endcase
    end
  end

  wcs_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_req(in_req),
    .closed(closed_r), .passes(passes_r), .sts(sts), .cmd(cmd),
    .out_valid(out_valid), .show(show), .status(status),
    .point_count(point_count), .rotation_count(rotation_count)
  );

  wcs_dp u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .in_req(in_req), .weight(weight_r),
    .sts(sts), .rd_pt(rd_pt)
  );

  // point fields read as zero unless a read hit a valid index
  assign out_res.out_x          = show ? rd_pt.x : 32'sd0;
  assign out_res.out_y          = show ? rd_pt.y : 32'sd0;
  assign out_res.out_z          = show ? rd_pt.z : 32'sd0;
  assign out_res.out_break      = show & rd_pt.brk;
  assign out_res.point_count    = point_count;
  assign out_res.rotation_count = rotation_count;
  assign out_res.status         = status;

endmodule

/* tb/sv/weighted_curve_subdivider_top_test.sv */
// self-checking testbench of weighted_curve_subdivider_top: loads control points,
// runs curve subdivision and reads back points, checked against an in-bench predictor
// depends on wcs_pkg and the weighted_curve_subdivider_top RTL
`timescale 1ns / 100ps

module weighted_curve_subdivider_top_test;

  localparam int StoreDepth = 1024;
  localparam int StallLimit = 600000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  wcs_pkg::in_req_t in_req = '0;
  logic out_valid;
  wcs_pkg::out_res_t out_res;
  logic cfg_we = 1'b0;
  logic [1:0] cfg_index = wcs_pkg::CFG_CLOSED;
  logic [15:0] cfg_data = '0;

  weighted_curve_subdivider_top dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_req(in_req),
    .out_valid(out_valid), .out_res(out_res),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #6 clk = ~clk;

  // predictor state
  logic [31:0] curve_pts [3][StoreDepth+1];
  logic [31:0] work_pts [3][StoreDepth+1];
  bit curve_brk [StoreDepth+1];
  int pending_loads = 0;
  int shaped_count = 0;
  int rotations = 0;
  bit closed_mode = 1'b0;
  int pass_count = 3;
  int weight = 2000;

  wcs_pkg::out_res_t point_q [$];
  int fail_count = 0;
  int idle_pct = 0;
  int stall_cycles = 0;

  // (ca*a + cb*b + cc*c) / d rounded to nearest, ties up
  function automatic logic [31:0] blend(logic [31:0] a, longint unsigned ca,
      logic [31:0] b, longint unsigned cb, logic [31:0] c, longint unsigned cc,
      longint unsigned d);
    longint unsigned acc;
    longint unsigned q;
    acc = ca * {32'b0, a ^ 32'h8000_0000} + cb * {32'b0, b ^ 32'h8000_0000}
        + cc * {32'b0, c ^ 32'h8000_0000} + d / 2;
    q = acc / d;
    return q[31:0] ^ 32'h8000_0000;
  endfunction

  function automatic logic [31:0] mid(logic [31:0] a, logic [31:0] b);
    return blend(a, 1, b, 1, 32'd0, 0, 2);
  endfunction

  function automatic logic [31:0] pull(logic [31:0] l, logic [31:0] r, logic [31:0] p);
    return blend(l, 1000, r, 1000, p, weight, weight + 2000);
  endfunction

  function automatic void refine_run(int d, int base, int len, bit loop);
    bit weighted;
    int c;
    logic [31:0] head_pt, m01, a, m, np;
    weighted = loop || len > 2;
    c = len;
    for (int ps = 0; ps < pass_count; ps++) begin
      head_pt = '0;
      m01 = mid(work_pts[d][base], work_pts[d][base+1]);
      if (loop) head_pt = pull(m01, mid(work_pts[d][base+c-2], work_pts[d][base+c-1]),
                               work_pts[d][base]);
      else work_pts[d][base+2*(c-1)] = work_pts[d][base+c-1];
      for (int j = c - 2; j >= 1; j--) begin
        a = work_pts[d][base+j];
        m = mid(a, work_pts[d][base+j+1]);
        np = weighted ? pull(mid(work_pts[d][base+j-1], a), m, a) : a;
        work_pts[d][base+2*j+1] = m;
        work_pts[d][base+2*j] = np;
      end
      work_pts[d][base+1] = m01;
      if (loop) begin
        work_pts[d][base] = head_pt;
        work_pts[d][base+2*(c-1)] = head_pt;
      end
      c = 2 * c - 1;
    end
  endfunction

  function automatic logic [1:0] shape_curve(int n);
    longint segs, total;
    int k, m, s, cnt, p;
    bit anybreak;
    logic [31:0] tmp [3][StoreDepth+1];
    bit tmpb [StoreDepth+1];
    p = pass_count;
    anybreak = 1'b1;
    k = 0;
    if (n < 2) begin
      shaped_count = n;
      rotations = 0;
      return wcs_pkg::STAT_FEW;
    end
    segs = closed_mode ? n : n - 1;
    total = (segs << p) + 1;
    if (total > StoreDepth) begin
      shaped_count = n;
      rotations = 0;
      return wcs_pkg::STAT_CAP;
    end
    rotations = 0;
    if (!closed_mode) begin
      curve_brk[0] = 1'b1;
      curve_brk[n-1] = 1'b1;
      m = n;
    end else begin
      while (k < n && !curve_brk[k]) k++;
      if (k < n) begin
        rotations = k;
        for (int i = 0; i < n; i++) begin
          for (int d = 0; d < 3; d++) tmp[d][i] = curve_pts[d][(i+k)%n];
          tmpb[i] = curve_brk[(i+k)%n];
        end
        for (int i = 0; i < n; i++) begin
          for (int d = 0; d < 3; d++) curve_pts[d][i] = tmp[d][i];
          curve_brk[i] = tmpb[i];
        end
      end else anybreak = 1'b0;
      for (int d = 0; d < 3; d++) curve_pts[d][n] = curve_pts[d][0];
      curve_brk[n] = curve_brk[0];
      m = n + 1;
    end
    if (!anybreak) begin
      for (int d = 0; d < 3; d++) begin
        for (int i = 0; i < m; i++) work_pts[d][i] = curve_pts[d][i];
        refine_run(d, 0, m, 1'b1);
      end
    end else begin
      s = 0;
      for (int i = 1; i < m; i++) begin
        if (curve_brk[i]) begin
          for (int d = 0; d < 3; d++) begin
            for (int j = 0; j <= i - s; j++) work_pts[d][(s<<p)+j] = curve_pts[d][s+j];
            refine_run(d, s << p, i - s + 1, 1'b0);
          end
          s = i;
        end
      end
    end
    cnt = int'(total);
    for (int i = cnt - 1; i >= 0; i--)
      curve_brk[i] = ((i & ((1 << p) - 1)) == 0) ? curve_brk[i >> p] : 1'b0;
    for (int d = 0; d < 3; d++) begin
      for (int i = 0; i < cnt; i++) begin
        if (i > 0 && i + 1 < cnt && !curve_brk[i])
          curve_pts[d][i] = blend(work_pts[d][i-1], 1000, work_pts[d][i+1], 1000,
                                  work_pts[d][i], weight + 2000, weight + 4000);
        else curve_pts[d][i] = work_pts[d][i];
      end
      if (!anybreak) begin
        curve_pts[d][0] = blend(work_pts[d][cnt-2], 1000, work_pts[d][1], 1000,
                                work_pts[d][0], weight + 2000, weight + 4000);
        curve_pts[d][cnt-1] = curve_pts[d][0];
      end
    end
    shaped_count = cnt;
    return wcs_pkg::STAT_OK;
  endfunction

  function automatic wcs_pkg::out_res_t predict_point(wcs_pkg::in_req_t r);
    wcs_pkg::out_res_t res;
    res = '0;
    res.status = wcs_pkg::STAT_OK;
    if (r.operation == wcs_pkg::OP_LOAD) begin
      if (pending_loads < StoreDepth) begin
        curve_pts[0][pending_loads] = r.coord_x;
        curve_pts[1][pending_loads] = r.coord_y;
        curve_pts[2][pending_loads] = r.coord_z;
        curve_brk[pending_loads] = r.break_point;
        pending_loads++;
      end else res.status = wcs_pkg::STAT_CAP;
      if (r.last_point) begin
        res.status = shape_curve(pending_loads);
        pending_loads = 0;
      end
    end else if (int'(r.read_index) < shaped_count) begin
      res.out_x = curve_pts[0][r.read_index];
      res.out_y = curve_pts[1][r.read_index];
      res.out_z = curve_pts[2][r.read_index];
      res.out_break = curve_brk[r.read_index];
    end else res.status = wcs_pkg::STAT_INDEX;
    res.point_count = shaped_count[10:0];
    res.rotation_count = rotations[9:0];
    return res;
  endfunction

  task automatic send_req(wcs_pkg::in_req_t r);
    while ($urandom_range(0, 99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    in_req <= r;
    do @(posedge clk); while (busy);
    point_q.push_back(predict_point(r));
  endtask

  function automatic logic [31:0] rand_coord();
    case ($urandom_range(0, 3))
      0: return $urandom;
      1: return 32'h7FFF_FFFF - $urandom_range(0, 3);
      2: return 32'h8000_0000 + $urandom_range(0, 3);
      default: return $urandom_range(0, 32'h0010_0000) - 32'h0008_0000;
    endcase
  endfunction

  task automatic load_point(logic [31:0] x, logic [31:0] y, logic [31:0] z,
                            bit brk, bit last);
    wcs_pkg::in_req_t r;
    r = '0;
    r.operation = wcs_pkg::OP_LOAD;
    r.coord_x = x;
    r.coord_y = y;
    r.coord_z = z;
    r.break_point = brk;
    r.last_point = last;
    r.read_index = 10'($urandom);
    send_req(r);
  endtask

  task automatic read_point(int idx);
    wcs_pkg::in_req_t r;
    r = '0;
    r.operation = wcs_pkg::OP_READ;
    r.coord_x = $urandom;
    r.coord_y = $urandom;
    r.coord_z = $urandom;
    r.break_point = 1'($urandom_range(0, 1));
    r.last_point = 1'($urandom_range(0, 1));
    r.read_index = idx[9:0];
    send_req(r);
  endtask

  task automatic read_all();
    for (int i = 0; i < shaped_count; i++) read_point(i);
  endtask

  task automatic drain();
    start <= 1'b0;
    while (point_q.size() != 0 || busy) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [15:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
  endtask

  task automatic set_mode(bit closed, int passes, int w);
    drain();
    write_reg(wcs_pkg::CFG_CLOSED, {15'b0, closed});
    write_reg(wcs_pkg::CFG_PASSES, passes[15:0]);
    write_reg(wcs_pkg::CFG_WEIGHT, w[15:0]);
    cfg_we <= 1'b0;
    closed_mode = closed;
    pass_count = passes;
    weight = w;
  endtask

  // bad index before any result, too few points, capacity
  task automatic test_error_status();
    read_point(0);
    read_point(1023);
    load_point(rand_coord(), rand_coord(), rand_coord(), 1'b0, 1'b1);
    read_point(0);
    set_mode(1'b0, 10, 2000);
    load_point(32'h7FFF_FFFF, 32'h8000_0000, 32'd0, 1'b0, 1'b0);
    load_point(32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 1'b1, 1'b1);
    read_all();
    read_point(2);
  endtask

  task automatic test_open_curve();
    set_mode(1'b0, 2, 0);
    load_point(32'h7FFF_FFFF, 32'h8000_0000, 32'h0001_0000, 1'b0, 1'b0);
    load_point(32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_0000, 1'b1, 1'b0);
    load_point(32'h0002_0000, 32'h0003_0000, 32'h0000_8000, 1'b0, 1'b0);
    load_point(32'hFFFF_FFFF, 32'd1, 32'h4000_0000, 1'b0, 1'b1);
    read_all();
    // loads land over the results just computed
    load_point(32'h1234_5678, 32'h8765_4321, 32'h0, 1'b1, 1'b0);
    read_point(0);
    read_point(1);
    load_point(32'h0, 32'h0, 32'h0, 1'b0, 1'b1);
    read_all();
  endtask

  task automatic test_closed_curve();
    set_mode(1'b1, 2, 65535);
    load_point(32'h0001_0000, 32'h0, 32'h7FFF_FFFF, 1'b0, 1'b0);
    load_point(32'h0, 32'h0001_0000, 32'h8000_0000, 1'b0, 1'b0);
    load_point(32'hFFFF_0000, 32'h0, 32'h0, 1'b1, 1'b1);
    read_all();
    set_mode(1'b1, 3, 2000);
    load_point(32'h0005_0000, 32'h0, 32'h0, 1'b0, 1'b0);
    load_point(32'h0, 32'h0005_0000, 32'h0, 1'b0, 1'b0);
    load_point(32'hFFFB_0000, 32'h0, 32'h0, 1'b0, 1'b1);
    read_point(0);
    read_point(shaped_count - 1);
    read_point(shaped_count);
  endtask

  // a run of two points refines by plain midpoints before smoothing, deepest legal refinement
  task automatic test_two_point_deep();
    set_mode(1'b0, 9, 1234);
    load_point(32'h8000_0000, 32'h7FFF_FFFF, 32'h0, 1'b0, 1'b0);
    load_point(32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF, 1'b0, 1'b1);
    read_point(0);
    read_point(256);
    read_point(512);
    read_point(513);
  endtask

  // one load more than the store holds is dropped
  task automatic test_store_full();
    set_mode(1'b0, 0, 3000);
    for (int i = 0; i < StoreDepth; i++)
      load_point(rand_coord(), rand_coord(), rand_coord(), $urandom_range(0, 3) == 0, 1'b0);
    load_point(rand_coord(), rand_coord(), rand_coord(), 1'b0, 1'b1);
    read_point(0);
    read_point(StoreDepth - 1);
    read_point($urandom_range(1, StoreDepth - 2));
  endtask

  task automatic test_random_curves(int items);
    int sent, n, reads, wsel, w;
    bit drop_last;
    sent = 0;
    for (int ph = 0; ph < 4; ph++) begin
      wsel = $urandom_range(0, 3);
      w = (wsel == 0) ? 0 : (wsel == 1) ? 65535 : (wsel == 2) ? 2000 : $urandom_range(0, 65535);
      set_mode(1'($urandom_range(0, 1)),
               ($urandom_range(0, 9) == 0) ? 4 : $urandom_range(0, 3), w);
      idle_pct = (ph == 1) ? 49 : (ph == 3) ? 37 : 0;
      while (sent < (ph + 1) * items / 4) begin
        n = ($urandom_range(0, 19) == 0) ? 1 : $urandom_range(2, 6);
        drop_last = $urandom_range(0, 9) == 0;
        for (int i = 0; i < n; i++)
          load_point(rand_coord(), rand_coord(), rand_coord(), $urandom_range(0, 3) == 0,
                     (i == n - 1) && !drop_last);
        reads = $urandom_range(2, 6);
        for (int i = 0; i < reads; i++)
          read_point(($urandom_range(0, 9) == 0 || shaped_count == 0) ?
                     $urandom_range(0, 1023) : $urandom_range(0, shaped_count - 1));
        sent += n + reads;
      end
    end
  endtask

  always @(posedge clk) begin
    wcs_pkg::out_res_t want;
    if (rst_n && out_valid) begin
      if (point_q.size() == 0) begin
        $error("unexpected result, status %0d", out_res.status);
        fail_count++;
      end else begin
        want = point_q.pop_front();
        if (out_res.out_x !== want.out_x) begin
          $error("out_x exp %h got %h", want.out_x, out_res.out_x);
          fail_count++;
        end
        if (out_res.out_y !== want.out_y) begin
          $error("out_y exp %h got %h", want.out_y, out_res.out_y);
          fail_count++;
        end
        if (out_res.out_z !== want.out_z) begin
          $error("out_z exp %h got %h", want.out_z, out_res.out_z);
          fail_count++;
        end
        if (out_res.out_break !== want.out_break) begin
          $error("out_break exp %b got %b", want.out_break, out_res.out_break);
          fail_count++;
        end
        if (out_res.point_count !== want.point_count) begin
          $error("point_count exp %0d got %0d", want.point_count, out_res.point_count);
          fail_count++;
        end
        if (out_res.rotation_count !== want.rotation_count) begin
          $error("rotation_count exp %0d got %0d", want.rotation_count,
                 out_res.rotation_count);
          fail_count++;
        end
        if (out_res.status !== want.status) begin
          $error("status exp %0d got %0d", want.status, out_res.status);
          fail_count++;
        end
      end
    end
  end

  // no request taken and no result for too long
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid) stall_cycles <= 0;
    else stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= StallLimit) begin
      $display("weighted_curve_subdivider_top_test NOT OK");
      $finish;
    end
  end

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_error_status();
    test_open_curve();
    test_closed_curve();
    test_two_point_deep();
    test_store_full();
    test_random_curves(210);
    drain();
    repeat (50) @(posedge clk);
    if (fail_count == 0) begin
      $display("weighted_curve_subdivider_top_test OK");
    end else begin
      $display("weighted_curve_subdivider_top_test NOT OK");
    end
    $finish;
  end

endmodule

/* sim.f */
+incdir+rtl
rtl/wcs_pkg.sv
rtl/wcs_lane.sv
rtl/wcs_dp.sv
rtl/wcs_ctrl.sv
rtl/weighted_curve_subdivider_top.sv
tb/sv/weighted_curve_subdivider_top_test.sv
